// ===== design/i2a_pkg.sv =====
// ----------------------------------------------------------------------------
// i2a_pkg
// shared constants, cell operation codes and the digit-to-ascii helper for
// the integer to ascii formatter
// ----------------------------------------------------------------------------
package i2a_pkg;

    localparam int unsigned DIGITS   = 10;  // decimal digits of a 32-bit magnitude
    localparam int unsigned HEX_MAX  = 8;   // nibbles in a 32-bit word
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned COUNT_W  = 4;
    localparam int unsigned CHAR_W   = 7;
    localparam int unsigned NIB_W    = 4;
    localparam int unsigned POS_W    = $clog2(DIGITS + 1);
    localparam int unsigned STEP_W   = $clog2(VALUE_W);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;  // '0'
    localparam logic [CHAR_W-1:0] CHAR_UPPER = 7'h41;  // 'A'
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;  // '-'

    localparam logic OP_DEC = 1'b0;
    localparam logic OP_HEX = 1'b1;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_DABBLE,
        CELL_SHIFT
    } t_cell_op;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [NIB_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10) begin
            c = CHAR_ZERO + {3'b000, d};
        end else begin
            c = CHAR_UPPER + {3'b000, d - 4'd10};
        end
        return c;
    endfunction

endpackage

// ===== design/i2a_digit_cell.sv =====
// ----------------------------------------------------------------------------
// i2a_digit_cell
// one bcd digit of the conversion chain: shift-and-add-3 step, parallel
// load, or digit shift from the lower neighbor toward the top of the chain
// ----------------------------------------------------------------------------
module i2a_digit_cell
    import i2a_pkg::*;
(
    input  logic             i_clk,
    input  t_cell_op         i_cell_op,
    input  logic [NIB_W-1:0] i_load,
    input  logic             i_carry,
    input  logic [NIB_W-1:0] i_lower,
    output logic             o_carry,
    output logic [NIB_W-1:0] o_digit
);

    logic [NIB_W-1:0] r_digit;
    logic [NIB_W-1:0] n_adj;

    // a digit of five or more overflows on the next doubling
    assign n_adj   = (r_digit >= 4'd5) ? r_digit + 4'd3 : r_digit;
    assign o_carry = n_adj[NIB_W-1];
    assign o_digit = r_digit;

    always_ff @(posedge i_clk) begin
        unique case (i_cell_op)
            CELL_HOLD:   r_digit <= r_digit;
            CELL_LOAD:   r_digit <= i_load;
            CELL_DABBLE: r_digit <= {n_adj[NIB_W-2:0], i_carry};
            CELL_SHIFT:  r_digit <= i_lower;
            default:     r_digit <= r_digit;
        endcase
    end

endmodule

// ===== design/integer_to_ascii_formatter_unit.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_unit
// formats a 32-bit number as signed decimal or fixed-width uppercase hex
// ----------------------------------------------------------------------------
// Pulse start while busy is low to hand over one item; busy stays high until
// the last character has been issued. Characters come out one per cycle on
// o_character with o_valid high for exactly one cycle each, and the receiver
// cannot hold them off, so it must take every strobe. A row of ten bcd digit
// cells does the work: decimal items run a shift-and-add-3 step through the
// row for each bit of the magnitude, then leading zeros are shifted out of
// the top cell, a minus sign is issued for a negative item and the digits
// follow. Hex items load the nibbles straight into the row, shift the unused
// top positions out and then issue count digits; a count of zero issues
// nothing and leaves the block idle. Counts above eight act as eight.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_unit
    import i2a_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_op,
    input  logic [VALUE_W-1:0] i_value,
    input  logic [COUNT_W-1:0] i_digit_count,
    output logic               o_valid,
    output logic [CHAR_W-1:0]  o_character,
    output logic               o_last
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } t_state;

    t_state             r_state;
    logic               r_hex;
    logic               r_neg;
    logic [VALUE_W-1:0] r_bin;
    logic [STEP_W-1:0]  r_step;
    logic [POS_W-1:0]   r_cnt;
    logic [COUNT_W-1:0] r_len;
    logic               r_valid;
    logic [CHAR_W-1:0]  r_char;
    logic               r_last;

    logic                     w_accept;
    logic [COUNT_W-1:0]       w_len;
    logic [VALUE_W-1:0]       w_mag;
    logic [DIGITS*NIB_W-1:0]  w_load;
    logic                     w_skip;
    t_cell_op                 w_cell_op;
    logic [NIB_W-1:0]         w_digit [DIGITS];
    logic                     w_carry [DIGITS+1];
    logic [NIB_W-1:0]         w_top;

    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && !busy;
    assign w_len    = (i_digit_count > COUNT_W'(HEX_MAX)) ? COUNT_W'(HEX_MAX) : i_digit_count;
    assign w_mag    = i_value[VALUE_W-1] ? (VALUE_W'(0) - i_value) : i_value;
    assign w_load   = (i_op == OP_HEX) ? {{((DIGITS - HEX_MAX) * NIB_W){1'b0}}, i_value}
                                       : '0;
    assign w_top    = w_digit[DIGITS-1];

    // shift off unused top positions: fixed width for hex, leading zeros for decimal
    assign w_skip = r_hex ? (r_cnt > POS_W'(r_len))
                          : ((w_top == '0) && (r_cnt > POS_W'(1)));

    always_comb begin
        unique case (r_state)
            ST_IDLE:    w_cell_op = w_accept ? CELL_LOAD : CELL_HOLD;
            ST_CONVERT: w_cell_op = CELL_DABBLE;
            ST_SKIP:    w_cell_op = w_skip ? CELL_SHIFT : CELL_HOLD;
            ST_SIGN:    w_cell_op = CELL_HOLD;
            ST_EMIT:    w_cell_op = CELL_SHIFT;
            default:    w_cell_op = CELL_HOLD;
        endcase
    end

    assign w_carry[0] = r_bin[VALUE_W-1];

    for (genvar k = 0; k < DIGITS; k++) begin : g_cell
        i2a_digit_cell u_cell (
            .i_clk     (i_clk),
            .i_cell_op (w_cell_op),
            .i_load    (w_load[k*NIB_W +: NIB_W]),
            .i_carry   (w_carry[k]),
            .i_lower   ((k == 0) ? NIB_W'(0) : w_digit[(k == 0) ? 0 : k - 1]),
            .o_carry   (w_carry[k+1]),
            .o_digit   (w_digit[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_hex  <= (i_op == OP_HEX);
                        r_neg  <= i_value[VALUE_W-1];
                        r_bin  <= w_mag;
                        r_step <= '0;
                        r_cnt  <= POS_W'(DIGITS);
                        r_len  <= w_len;
                        if (i_op == OP_HEX) begin
                            r_state <= (w_len == '0) ? ST_IDLE : ST_SKIP;
                        end else begin
                            r_state <= ST_CONVERT;
                        end
                    end
                end
                ST_CONVERT: begin
                    r_bin  <= {r_bin[VALUE_W-2:0], 1'b0};
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(VALUE_W - 1)) begin
                        r_state <= ST_SKIP;
                    end
                end
                ST_SKIP: begin
                    if (w_skip) begin
                        r_cnt <= r_cnt - POS_W'(1);
                    end else if (!r_hex && r_neg) begin
                        r_state <= ST_SIGN;
                    end else begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_SIGN: begin
                    r_valid <= 1'b1;
                    r_char  <= CHAR_MINUS;
                    r_last  <= 1'b0;
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    r_valid <= 1'b1;
                    r_char  <= digit_char(w_top);
                    r_last  <= (r_cnt == POS_W'(1));
                    r_cnt   <= r_cnt - POS_W'(1);
                    if (r_cnt == POS_W'(1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_valid     = r_valid;
    assign o_character = r_char;
    assign o_last      = r_last;

    // a 32-bit magnitude never carries out of the top decimal digit
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CONVERT) |-> !w_carry[DIGITS])
        else $error("bcd chain carried out of the top digit");

    a_emit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_cnt != '0))
        else $error("emitting with no digit left");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !o_valid)
        else $error("character issued right after last of an item");

    a_accept_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_valid)
        else $error("character issued right after a new item was taken");

endmodule
